>>> hw/rtl/fcs_pkg.sv
// shared types, fold function and character encoding table for the checksum block
`default_nettype none

package fcs_pkg;

	localparam int FOLD_INTERVAL_DEF = 720;
	// holds one folded half plus the words of the widest fold interval
	localparam int ACC_W = 26;

	// register index decoded from paddr[2]
	localparam logic REG_SEED_SUM = 1'b0;

	typedef logic [ACC_W-1:0] acc_t;
	typedef logic [31:0] sum_t;
	typedef logic [7:0] char_t;
	// four characters for one sum byte, first character in the top byte
	typedef logic [31:0] enc_row_t;
	typedef enc_row_t enc_table_t [256];

	localparam char_t PUNCT_CODES [13] = '{
		8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40,
		8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f, 8'h60
	};

	// end-around carry fold of both halves; settles within four crosswise steps
	function automatic sum_t fold_sum(acc_t h, acc_t l);
		logic [16:0] fh;
		logic [16:0] fl;
		logic [16:0] th;
		fh = {1'b0, h[15:0]} + 17'(l[ACC_W-1:16]);
		fl = {1'b0, l[15:0]} + 17'(h[ACC_W-1:16]);
		for (int i = 0; i < 3; i++) begin
			th = {1'b0, fh[15:0]} + 17'(fl[16]);
			fl = {1'b0, fl[15:0]} + 17'(fh[16]);
			fh = th;
		end
		return {fh[15:0], fl[15:0]};
	endfunction

	// spread one byte over four characters, stepping pairs away from punctuation
	function automatic enc_row_t enc_byte(int b);
		int c [4];
		int q;
		int pass;
		bit changed;
		q = (b >> 2) + 48;
		c[0] = q + (b & 3);
		c[1] = q;
		c[2] = q;
		c[3] = q;
		changed = 1'b1;
		for (pass = 0; pass < 64 && changed; pass++) begin
			changed = 1'b0;
			for (int k = 0; k < 13; k++) begin
				for (int j = 0; j < 4; j += 2) begin
					if (c[j] == int'(PUNCT_CODES[k]) || c[j+1] == int'(PUNCT_CODES[k])) begin
						c[j] = c[j] + 1;
						c[j+1] = c[j+1] - 1;
						changed = 1'b1;
					end
				end
			end
		end
		return {8'(c[0]), 8'(c[1]), 8'(c[2]), 8'(c[3])};
	endfunction

	function automatic enc_table_t build_enc_table();
		enc_table_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = enc_byte(i);
		end
		return t;
	endfunction

	localparam enc_table_t ENC_TABLE = build_enc_table();

endpackage

`default_nettype wire

>>> hw/rtl/fcs_encode.sv
// ascii encoding of the complemented combined sum into sixteen characters
`default_nettype none

module fcs_encode (
	input  wire fcs_pkg::sum_t combined,
	output logic [63:0]         chars_first,
	output logic [63:0]         chars_second
);
	import fcs_pkg::*;

	sum_t  value;
	char_t grid [16];
	char_t text [16];

	assign value = ~combined;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			for (int j = 0; j < 4; j++) begin
				grid[4*j+b] = ENC_TABLE[value[31-8*b -: 8]][31-8*j -: 8];
			end
		end
		// characters rotate right by one
		text[0] = grid[15];
		for (int i = 1; i < 16; i++) begin
			text[i] = grid[i-1];
		end
		for (int i = 0; i < 8; i++) begin
			chars_first[63-8*i -: 8]  = text[i];
			chars_second[63-8*i -: 8] = text[8+i];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fits_checksum_stream.sv
// streaming 32-bit ones-complement checksum with ascii encoding of the result
//
//   port group      dir  handshake               contents
//   data_*          in   data_valid/data_ready   data_byte, last_byte
//   result_*        out  result_valid/result_ready  stream_sum, combined_sum,
//                                                chars_first_half, chars_second_half,
//                                                sum_verifies
//   apb             in   psel/penable, pready=1  seed_sum at byte address 0
//
// one byte is taken every cycle while data_ready is high; the pair add and periodic
// fold close as the byte is taken; a last byte leaves the accumulators through three
// stages (fold, seed add, encode), held in s1, s2, s3 and the result register as
// result_ready allows; the pipe holds up to four words before data_ready drops
// reset clears the seed, the stream state and all stage valids

`default_nettype none

module fits_checksum_stream #(
	parameter int FOLD_INTERVAL = fcs_pkg::FOLD_INTERVAL_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         data_valid,
	output logic        data_ready,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        result_valid,
	input  wire         result_ready,
	output logic [31:0] stream_sum,
	output logic [31:0] combined_sum,
	output logic [63:0] chars_first_half,
	output logic [63:0] chars_second_half,
	output logic        sum_verifies
);
	import fcs_pkg::*;

	localparam int PHASE_W = (FOLD_INTERVAL > 2) ? $clog2(FOLD_INTERVAL) : 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(FOLD_INTERVAL - 1);

	sum_t               seed_q;
	acc_t               hacc_q;
	acc_t               lacc_q;
	logic [PHASE_W-1:0] phase_q;
	logic               parity_q;
	logic [7:0]         held_byte_q;
	logic               held_valid_q;

	acc_t               hacc_n;
	acc_t               lacc_n;
	logic [PHASE_W-1:0] phase_n;
	sum_t               folded;
	logic [15:0]        word;
	logic               data_fire;
	logic               cfg_write;

	logic               valid_s1;
	acc_t               hacc_s1;
	acc_t               lacc_s1;
	logic               valid_s2;
	sum_t               stream_s2;
	logic               valid_s3;
	sum_t               stream_s3;
	sum_t               combined_s3;
	logic               result_valid_q;

	logic               take1;
	logic               take2;
	logic               take3;
	sum_t               stream_fold;
	sum_t               combined_fold;
	logic [63:0]        chars_first;
	logic [63:0]        chars_second;

	// config port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_SEED_SUM) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_write && paddr[2] == REG_SEED_SUM) begin
			seed_q <= pwdata;
		end
	end

	// stage ready chain
	assign take3      = !result_valid_q || result_ready;
	assign take2      = !valid_s3 || take3;
	assign take1      = !valid_s2 || take2;
	assign data_ready = !valid_s1 || take1;
	assign data_fire  = data_valid && data_ready;

	// pair add into the accumulator picked by word parity, fold at interval end
	assign word = {held_byte_q, data_byte};

	always_comb begin
		hacc_n  = hacc_q;
		lacc_n  = lacc_q;
		phase_n = phase_q;
		folded  = '0;
		if (held_valid_q) begin
			if (!parity_q) begin
				hacc_n = hacc_q + ACC_W'(word);
			end else begin
				lacc_n = lacc_q + ACC_W'(word);
			end
			if (phase_q == PHASE_LAST) begin
				folded  = fold_sum(hacc_n, lacc_n);
				hacc_n  = ACC_W'(folded[31:16]);
				lacc_n  = ACC_W'(folded[15:0]);
				phase_n = '0;
			end else begin
				phase_n = phase_q + PHASE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hacc_q       <= '0;
			lacc_q       <= '0;
			phase_q      <= '0;
			parity_q     <= 1'b0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
		end else if (data_fire) begin
			if (last_byte) begin
				hacc_q       <= '0;
				lacc_q       <= '0;
				phase_q      <= '0;
				parity_q     <= 1'b0;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
			end else if (held_valid_q) begin
				hacc_q       <= hacc_n;
				lacc_q       <= lacc_n;
				phase_q      <= phase_n;
				parity_q     <= !parity_q;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
			end else begin
				held_byte_q  <= data_byte;
				held_valid_q <= 1'b1;
			end
		end
	end

	// result pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (data_fire && last_byte) begin
				valid_s1 <= 1'b1;
			end else if (take1) begin
				valid_s1 <= 1'b0;
			end
			if (take1) begin
				valid_s2 <= valid_s1;
			end
			if (take2) begin
				valid_s3 <= valid_s2;
			end
			if (take3) begin
				result_valid_q <= valid_s3;
			end
		end
	end

	assign stream_fold   = fold_sum(hacc_s1, lacc_s1);
	assign combined_fold = fold_sum(ACC_W'(seed_q[31:16]) + ACC_W'(stream_s2[31:16]),
		ACC_W'(seed_q[15:0]) + ACC_W'(stream_s2[15:0]));

	fcs_encode u_encode (
		.combined     (combined_s3),
		.chars_first  (chars_first),
		.chars_second (chars_second)
	);

	// result pipe payload
	always_ff @(posedge clk) begin
		if (data_fire && last_byte) begin
			hacc_s1 <= hacc_n;
			lacc_s1 <= lacc_n;
		end
		if (take1 && valid_s1) begin
			stream_s2 <= stream_fold;
		end
		if (take2 && valid_s2) begin
			stream_s3   <= stream_s2;
			combined_s3 <= combined_fold;
		end
		if (take3 && valid_s3) begin
			stream_sum        <= stream_s3;
			combined_sum      <= combined_s3;
			chars_first_half  <= chars_first;
			chars_second_half <= chars_second;
			sum_verifies      <= (combined_s3 == '0) || (combined_s3 == '1);
		end
	end

	assign result_valid = result_valid_q;

endmodule

`default_nettype wire
